// ===== src/cce_pkg.sv =====
// Shared types, constants and the code translation table for the
// calculator character set expander. No dependencies.
package cce_pkg;

  // Longest escape run and default depth of the front-to-back queue
  localparam int unsigned RUN_MAX     = 7;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Codes from this one up fold to 7 bits, except the line feed escape
  localparam logic [7:0] FOLD_LO_CODE = 8'd130;
  localparam logic [7:0] LF_ESC_CODE  = 8'd138;
  localparam logic [7:0] BSLASH_CODE  = 8'd92;
  localparam logic [7:0] DEL_CODE     = 8'd127;
  localparam logic [7:0] COLON_CODE   = 8'd128;
  localparam logic [7:0] YBAR_CODE    = 8'd129;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // One classified item: byte run, its length (1..7) and the text end mark
  typedef struct packed {
    logic [2:0]         len;
    logic [6:0][7:0]    bytes;
    logic               text_last;
  } run_t;

  // Build a run with bytes[0] sent first
  function automatic run_t mk_run(input logic [2:0] len,
                                  input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [7:0] b4, input logic [7:0] b5,
                                  input logic [7:0] b6);
    run_t r;
    r.len       = len;
    r.bytes     = {b6, b5, b4, b3, b2, b1, b0};
    r.text_last = 1'b0;
    return r;
  endfunction

  // Fold codes from FOLD_LO_CODE up (but not the line feed escape), then map the code to its run
  function automatic run_t xlat(input logic [7:0] code);
    logic [7:0] c;
    run_t       r;
    c = code;
    if (code >= FOLD_LO_CODE && code != LF_ESC_CODE) begin
      c = code & 8'h7F;
    end
    case (c)
      8'd0:  r = mk_run(3'd1, 8'hF7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd1:  r = mk_run(3'd1, 8'hD7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd2:  r = mk_run(3'd5, "\\", "s", "q", "r", "t", 8'h00, 8'h00);
      8'd3:  r = mk_run(3'd4, "\\", "i", "n", "t", 8'h00, 8'h00, 8'h00);
      8'd4:  r = mk_run(3'd6, "\\", "g", "r", "a", "y", "1", 8'h00);
      8'd5:  r = mk_run(3'd6, "\\", "S", "i", "g", "m", "a", 8'h00);
      8'd6:  r = mk_run(3'd1, ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd7:  r = mk_run(3'd3, "\\", "p", "i", 8'h00, 8'h00, 8'h00, 8'h00);
      8'd8:  r = mk_run(3'd1, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd9:  r = mk_run(3'd2, "<", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd11: r = mk_run(3'd2, ">", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd12: r = mk_run(3'd2, "!", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd13: r = mk_run(3'd2, "\\", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd14: r = mk_run(3'd1, "v", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd15: r = mk_run(3'd2, "-", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd16: r = mk_run(3'd2, "<", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd17: r = mk_run(3'd1, 8'hB5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd18: r = mk_run(3'd1, 8'hA3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd19: r = mk_run(3'd1, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd20: r = mk_run(3'd1, 8'hC5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd21: r = mk_run(3'd1, 8'hD1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd22: r = mk_run(3'd1, 8'hC4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd23: r = mk_run(3'd6, "\\", "a", "n", "g", "l", "e", 8'h00);
      8'd24: r = mk_run(3'd1, "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd25: r = mk_run(3'd1, 8'hC6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd26: r = mk_run(3'd3, ".", ".", ".", 8'h00, 8'h00, 8'h00, 8'h00);
      8'd27: r = mk_run(3'd4, "\\", "e", "s", "c", 8'h00, 8'h00, 8'h00);
      8'd28: r = mk_run(3'd1, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd29: r = mk_run(3'd1, 8'hDC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'd30: r = mk_run(3'd6, "\\", "g", "r", "a", "y", "2", 8'h00);
      8'd31: r = mk_run(3'd7, "\\", "b", "u", "l", "l", "e", "t");
      BSLASH_CODE: r = mk_run(3'd2, "\\", "\\", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      DEL_CODE:    r = mk_run(3'd2, "|", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      COLON_CODE:  r = mk_run(3'd1, ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      YBAR_CODE:   r = mk_run(3'd1, "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      LF_ESC_CODE: r = mk_run(3'd3, "\\", "L", "F", 8'h00, 8'h00, 8'h00, 8'h00);
      // Line feed and all other printable codes pass through
      default:     r = mk_run(3'd1, c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endcase
    return r;
  endfunction

endpackage

// ===== src/cce_front.sv =====
// Front end: accepts input beats, folds and classifies each code into a
// byte run. Depends on cce_pkg.
module cce_front
  import cce_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push,
  output run_t     push_run,
  input  logic     q_full
);

  // Accept whenever the queue has room
  assign in_ready = ~q_full;
  assign push     = in_valid & ~q_full;

  // Translate the code and attach the text end mark
  always_comb begin
    push_run           = xlat(in_item.char_code);
    push_run.text_last = in_item.text_last;
  end

endmodule

// ===== src/cce_queue.sv =====
// Short queue of classified runs between front and back.
// Depends on cce_pkg.
module cce_queue
  import cce_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_run,
  output logic full,
  output logic nonempty,
  input  logic pop,
  output run_t head_run
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  run_t            slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full     = (count_r == FullCnt);
  assign nonempty = (count_r != '0);
  assign head_run = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : PtrW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : PtrW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CntW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CntW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed run
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ===== src/cce_back.sv =====
// Back end: holds one run and sends its bytes one beat per cycle while out_ready is high.
// Depends on cce_pkg.
module cce_back
  import cce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  run_t      head_run,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  run_t       cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       at_end;
  logic       advance;

  assign at_end  = (idx_r == 3'(cur_r.len - 3'd1));
  assign advance = ~busy_r | (out_ready & at_end);
  assign pop     = advance & q_nonempty;

  // Drive the current byte from the held run
  assign out_valid         = busy_r;
  assign out_item.out_byte = cur_r.bytes[idx_r];
  assign out_item.run_last = at_end;
  assign out_item.text_end = at_end & cur_r.text_last;

  // Load the next run when idle or at the end of this one, else step through it
  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (advance) begin
      busy_nxt = q_nonempty;
      cur_nxt  = head_run;
      idx_nxt  = '0;
    end else if (out_ready) begin
      idx_nxt = 3'(idx_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

// ===== src/calc_charset_to_ascii_expander.sv =====
// Calculator character set to ASCII/Latin-1 expander, top level.
// An input is stored in a queue slot, then in the back end's run register.
// Takes one input per cycle for single-byte runs while out_ready is high;
// the serializer sends a run byte by byte, with QueueDepth runs buffered.
// Reset (rst_n, synchronous) empties the queue and idles the serializer.
// Depends on cce_pkg, cce_front, cce_queue, cce_back.
module calc_charset_to_ascii_expander
  import cce_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic push, pop, q_full, q_nonempty;
  run_t push_run, head_run;

  cce_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .push     (push),
    .push_run (push_run),
    .q_full   (q_full)
  );

  cce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (pop),
    .head_run (head_run)
  );

  cce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
